### rtl/atc_pkg.sv
// Shared constants, types and arctangent table for the accelerometer tilt block.
package atc_pkg;

  localparam int CAL_SAMPLES  = 10;
  localparam int ONE_G_COUNTS = 250;

  localparam int NSTEP = 34;
  localparam int G     = 32;
  localparam int F     = 24;
  localparam int AW    = 17;
  localparam int CW    = 18;
  localparam int XW    = 52;
  localparam int ZW    = 38;
  localparam int TW    = 39;
  localparam int SW    = 20;
  localparam int CNTW  = 4;
  localparam int OW    = 17;
  localparam int ANGW  = 15;
  localparam int IDXW  = $clog2(NSTEP);
  localparam int RUNW  = $clog2(NSTEP + 1);

  localparam int DIV_SH = 24;
  localparam int NW     = SW + 1;
  localparam int RW     = 24;
  localparam int EW     = NW;
  localparam int PW     = EW + 5;
  localparam longint DIV_R = (longint'(1) << DIV_SH) / (2 * CAL_SAMPLES)
                             + (((longint'(1) << DIV_SH) % (2 * CAL_SAMPLES)) != 0);

  localparam real PI = 3.14159265358979323846;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  typedef enum logic {
    OP_MEASURE = 1'b0,
    OP_CAL     = 1'b1
  } op_e;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } lane_t;

  typedef logic signed [ZW-1:0] atan_tab_t [NSTEP];

  // atan(2^-i) in 1/64 degree with F fraction bits
  function automatic atan_tab_t build_atan_tab();
    atan_tab_t t;
    real v;
    for (int i = 0; i < NSTEP; i++) begin
      v = $atan(2.0 ** (-i)) * 11520.0 / PI * (2.0 ** F);
      t[i] = ZW'(longint'(v));
    end
    return t;
  endfunction

  localparam atan_tab_t ATAN_TAB = build_atan_tab();

endpackage

### rtl/atc_if.sv
// Valid/ready channel interfaces for input samples and angle results.
interface atc_in_if;
  logic                           valid;
  logic                           ready;
  logic                           operation;
  logic signed [15:0]             accel_x;
  logic signed [15:0]             accel_y;
  logic signed [15:0]             accel_z;
  modport source (output valid, operation, accel_x, accel_y, accel_z, input ready);
  modport sink (input valid, operation, accel_x, accel_y, accel_z, output ready);
endinterface

interface atc_out_if;
  logic                           valid;
  logic                           ready;
  logic signed [atc_pkg::ANGW-1:0] angle_about_x;
  logic signed [atc_pkg::ANGW-1:0] angle_about_y;
  logic                           angles_valid;
  logic                           calibrated;
  modport source (output valid, angle_about_x, angle_about_y, angles_valid, calibrated,
                  input ready);
  modport sink (input valid, angle_about_x, angle_about_y, angles_valid, calibrated,
                output ready);
endinterface

### rtl/atc_cell.sv
// One vectoring CORDIC cell, two lanes, registered output.
module atc_cell (
  input  logic                        clk_i,
  input  logic [atc_pkg::IDXW-1:0]    idx_i,
  input  atc_pkg::lane_t [1:0]        lane_i,
  output atc_pkg::lane_t [1:0]        lane_o
);
  import atc_pkg::*;

  lane_t [1:0] lane_d, lane_q;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      lane_d[l] = lane_i[l];
      if (lane_i[l].y > 0) begin
        lane_d[l].x = lane_i[l].x + (lane_i[l].y >>> idx_i);
        lane_d[l].y = lane_i[l].y - (lane_i[l].x >>> idx_i);
        lane_d[l].z = lane_i[l].z + ATAN_TAB[idx_i];
      end else if (lane_i[l].y < 0) begin
        lane_d[l].x = lane_i[l].x - (lane_i[l].y >>> idx_i);
        lane_d[l].y = lane_i[l].y + (lane_i[l].x >>> idx_i);
        lane_d[l].z = lane_i[l].z - ATAN_TAB[idx_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lane_q <= lane_d;
  end

  assign lane_o = lane_q;

endmodule

### rtl/accel_tilt_angles_with_calibration.sv
// Top level: calibration, offset correction, CORDIC cell chain and result register.
//
// Input channel in_i carries one sample per beat: operation (1 = calibration
// sample, 0 = measure) and raw x, y, z counts. Output channel out_o gives one
// beat per input beat, in order: two tilt angles in 1/64 degree, angles_valid
// (set for measure beats) and calibrated.
// Calibration beats are summed per axis; after CAL_SAMPLES of them the rounded
// means are turned into offsets through a registered quotient estimate and calibrated goes high.
// Measure beats add the offsets, fold each angle into the first octant and run
// it through a row of NSTEP registered CORDIC cells, both angles side by side;
// the octant is then unfolded and rounded to the nearest unit.
// One beat is in flight at a time. An accepted beat passes the cell row, the
// result register and the output register; in_i.ready rises in the same cycle
// as out_o.valid; no new beat is taken before the output register is loaded.
// The result sits in an output register, so a new beat is accepted while out_o
// is stalled; if the following result is finished before the stall clears, it
// is held and in_i.ready stays low.
// Reset clears sums, offsets and calibrated and leaves the block idle.
module accel_tilt_angles_with_calibration (
  input  logic      clk_i,
  input  logic      rst_ni,
  atc_in_if.sink    in_i,
  atc_out_if.source out_o
);
  import atc_pkg::*;

  state_e state_q, state_d;
  logic [RUNW-1:0] cnt_q;
  logic accept, run_end, out_load;

  logic signed [SW-1:0] sum_q [3];
  logic signed [SW-1:0] fin_sum_q [3];
  logic signed [SW-1:0] sum_new [3];
  logic [CNTW-1:0] cal_count_q, cal_count_new;
  logic signed [OW-1:0] off_q [3];
  logic offsets_ready_q, fin_q;

  logic [NW-1:0] div_n [3];
  logic [EW-1:0] est_q [3];
  logic [EW-1:0] q_val [3];
  logic signed [OW-1:0] mean [3];

  logic signed [CW-1:0] c_q [3];
  logic op_q;

  lane_t [1:0] chain [NSTEP+1];
  logic [AW-1:0] an [2], ad [2], amin [2], amax [2];
  logic signed [ANGW-1:0] ang [2];
  logic signed [ANGW-1:0] res_ang_q [2];
  logic res_valid_q, res_cal_q;

  logic out_valid_q;
  logic signed [ANGW-1:0] out_ang_q [2];
  logic out_av_q, out_cal_q;

  assign accept  = in_i.valid && in_i.ready;
  assign run_end = (state_q == ST_RUN) && (cnt_q == RUNW'(NSTEP));
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_RUN;
      ST_RUN:  if (run_end) state_d = ST_DONE;
      ST_DONE: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready = (state_q == ST_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (accept) cnt_q <= '0;
      else if (state_q == ST_RUN) cnt_q <= cnt_q + RUNW'(1);
    end
  end

  // calibration sums and rounded means
  assign cal_count_new = cal_count_q + CNTW'(1);
  always_comb begin
    sum_new[0] = sum_q[0] + SW'(in_i.accel_x);
    sum_new[1] = sum_q[1] + SW'(in_i.accel_y);
    sum_new[2] = sum_q[2] + SW'(in_i.accel_z);
    for (int k = 0; k < 3; k++) begin
      div_n[k] = NW'(fin_sum_q[k][SW-1] ? -fin_sum_q[k] : fin_sum_q[k]) * NW'(2)
                 + NW'(CAL_SAMPLES);
      q_val[k] = ((PW'(est_q[k]) * PW'(2 * CAL_SAMPLES)) > PW'(div_n[k]))
                 ? est_q[k] - EW'(1) : est_q[k];
      mean[k]  = fin_sum_q[k][SW-1] ? -OW'(q_val[k]) : OW'(q_val[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        sum_q[k] <= '0;
        off_q[k] <= '0;
      end
      cal_count_q     <= '0;
      offsets_ready_q <= 1'b0;
      fin_q           <= 1'b0;
    end else begin
      if (accept && in_i.operation == OP_CAL) begin
        if (32'(cal_count_new) >= CAL_SAMPLES) begin
          for (int k = 0; k < 3; k++) sum_q[k] <= '0;
          cal_count_q <= '0;
          fin_q       <= 1'b1;
        end else begin
          for (int k = 0; k < 3; k++) sum_q[k] <= sum_new[k];
          cal_count_q <= cal_count_new;
        end
      end
      if (fin_q && state_q == ST_RUN && cnt_q == RUNW'(1)) begin
        off_q[0] <= -mean[0];
        off_q[1] <= -mean[1];
        off_q[2] <= OW'(ONE_G_COUNTS) - mean[2];
        offsets_ready_q <= 1'b1;
        fin_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int k = 0; k < 3; k++) fin_sum_q[k] <= sum_new[k];
      op_q   <= in_i.operation;
      c_q[0] <= CW'(in_i.accel_x) + CW'(off_q[0]);
      c_q[1] <= CW'(in_i.accel_y) + CW'(off_q[1]);
      c_q[2] <= CW'(in_i.accel_z) + CW'(off_q[2]);
    end
    if (state_q == ST_RUN && cnt_q == '0) begin
      for (int k = 0; k < 3; k++) begin
        est_q[k] <= EW'(((NW + RW)'(div_n[k]) * (NW + RW)'(DIV_R)) >> DIV_SH);
      end
    end
  end

  // octant folding into the cell row
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      an[l]   = AW'(c_q[l][CW-1] ? -c_q[l] : c_q[l]);
      ad[l]   = AW'(c_q[2][CW-1] ? -c_q[2] : c_q[2]);
      amin[l] = (an[l] < ad[l]) ? an[l] : ad[l];
      amax[l] = (an[l] < ad[l]) ? ad[l] : an[l];
      chain[0][l].x = {{(XW-AW-G){1'b0}}, amax[l], {G{1'b0}}};
      chain[0][l].y = {{(XW-AW-G){1'b0}}, amin[l], {G{1'b0}}};
      chain[0][l].z = '0;
    end
  end

  for (genvar g = 0; g < NSTEP; g++) begin : g_cell
    atc_cell u_cell (
      .clk_i  (clk_i),
      .idx_i  (IDXW'(g)),
      .lane_i (chain[g]),
      .lane_o (chain[g+1])
    );
  end

  // unfold octant and round
  always_comb begin
    logic [TW-1:0] t;
    logic [TW-1:0] k;
    for (int l = 0; l < 2; l++) begin
      t = '0;
      if (amin[l] == '0) t = '0;
      else if (amin[l] == amax[l]) t = TW'(64'd2880 << F);
      else if (!chain[NSTEP][l].z[ZW-1]) t = TW'(chain[NSTEP][l].z);
      if (an[l] > ad[l]) t = TW'(64'd5760 << F) - t;
      if (c_q[2][CW-1]) t = TW'(64'd11520 << F) - t;
      k = (t + TW'(64'd1 << (F - 1))) >> F;
      ang[l] = c_q[l][CW-1] ? ANGW'(k) : -ANGW'(k);
    end
  end

  always_ff @(posedge clk_i) begin
    if (run_end) begin
      for (int l = 0; l < 2; l++) begin
        res_ang_q[l] <= (op_q == OP_CAL) ? '0 : ang[l];
      end
      res_valid_q <= (op_q == OP_MEASURE);
      res_cal_q   <= offsets_ready_q;
    end
    if (out_load) begin
      out_ang_q <= res_ang_q;
      out_av_q  <= res_valid_q;
      out_cal_q <= res_cal_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.angle_about_x = out_ang_q[0];
  assign out_o.angle_about_y = out_ang_q[1];
  assign out_o.angles_valid  = out_av_q;
  assign out_o.calibrated    = out_cal_q;

endmodule
